### design/histogram_valley_threshold_macros.svh
// Assertion macros for the histogram valley threshold block.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef HISTOGRAM_VALLEY_THRESHOLD_MACROS_SVH
`define HISTOGRAM_VALLEY_THRESHOLD_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define HVT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define HVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define HVT_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define HVT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### design/hvt_pkg.sv
// Package for the histogram valley threshold block: payload types, codes,
// kernel weights and per-bin reciprocals. No dependencies.
package hvt_pkg;

   localparam int unsigned NBINS         = 64;
   localparam int unsigned BIN_W         = 6;
   localparam int unsigned COUNT_W       = 21;
   localparam int unsigned SMOOTH_W      = 40;
   localparam int unsigned ACC_W         = 39;
   localparam int unsigned MUL_A_W       = 21;
   localparam int unsigned MUL_B_W       = 17;
   localparam int unsigned PROD_W        = MUL_A_W + MUL_B_W;
   localparam int unsigned KRADIUS       = 7;
   localparam int unsigned PEAK_GAP      = 5;
   localparam int unsigned FALLBACK_BIN  = 32;
   localparam int unsigned MAX_PIXELS_DEF = 1048576;
   localparam int unsigned PIXEL_BITS_DEF = 16;

   localparam logic [1:0] FUNC_ACCUM    = 2'd0;
   localparam logic [1:0] FUNC_FINISH   = 2'd1;
   localparam logic [1:0] FUNC_CLASSIFY = 2'd2;
   localparam logic [1:0] FUNC_UNDEF    = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] pixel_value;
   } req_type;

   typedef struct packed {
      logic       binary_out;
      logic [5:0] threshold_bin;
   } rsp_type;

   // Gaussian weight, Q1.16, by bin distance
   function automatic logic [MUL_B_W-1:0] kweight(input logic [BIN_W-1:0] d);
      logic [MUL_B_W-1:0] w;
      unique case (d)
         6'd0:    w = 17'd65536;
         6'd1:    w = 17'd52477;
         6'd2:    w = 17'd26943;
         6'd3:    w = 17'd8869;
         6'd4:    w = 17'd1872;
         6'd5:    w = 17'd253;
         6'd6:    w = 17'd22;
         6'd7:    w = 17'd1;
         default: w = 17'd0;
      endcase
      return w;
   endfunction

   // Rounded reciprocal of the kernel sum seen by bin i; depends on edge distance
   function automatic logic [15:0] recip(input logic [BIN_W-1:0] i);
      logic [BIN_W-1:0] e;
      logic [15:0]      r;
      e = i[5] ? (6'd63 - i) : i;
      unique case (e)
         6'd0:    r = 16'd27537;
         6'd1:    r = 16'd20604;
         6'd2:    r = 16'd18246;
         6'd3:    r = 16'd17583;
         6'd4:    r = 16'd17450;
         6'd5:    r = 16'd17432;
         default: r = 16'd17430;
      endcase
      return r;
   endfunction

endpackage

### design/histogram_valley_threshold.sv
// Histogram valley threshold: top level, the whole block in one module.
// Depends on hvt_pkg and histogram_valley_threshold_macros.svh.
//
// Usage. Items arrive on the req_ channel (valid/ready, one transfer per
// accepted item) and every item gives exactly one result on the rsp_ channel.
// Accumulate (func 0) counts the pixel in a 64-bin saturating histogram;
// classify (func 2) answers 1 when the pixel lies above the stored valley
// threshold; func 3 does nothing. Their results are loaded into the output
// register at acceptance. An accumulate keeps the block busy through a read
// then a write of the count memory port; a classify leaves it idle.
// Finish (func 1) smooths, finds both peaks and the valley, stores it and
// clears the histogram; its result appears once the search ends. Smoothing
// reads, multiplies and adds each kernel tap (904 taps in all), then scales
// and writes each bin, paced by the single shared 21x17 multiplier and one
// memory read per step; each peak pass reads and compares every bin, the
// valley pass each bin between the peaks, and a last step loads the result.
// The output register is one deep: while the receiver stalls, a waiting
// result holds and the block takes no further item.
// Reset clears the histogram valid bits at once (no sweep), sets the
// threshold to bin 32 and empties the output register.
module histogram_valley_threshold #(
   parameter int unsigned MAX_PIXELS = hvt_pkg::MAX_PIXELS_DEF,
   parameter int unsigned PIXEL_BITS = hvt_pkg::PIXEL_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hvt_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hvt_pkg::rsp_type rsp_payload
);

`include "histogram_valley_threshold_macros.svh"

   localparam int unsigned SH = PIXEL_BITS - 6;
   localparam int unsigned CW = (PIXEL_BITS > 16) ? PIXEL_BITS : 16;
   localparam logic [CW-1:0] PIX_MASK = {CW{1'b1}} >> (CW - PIXEL_BITS);
   localparam logic [hvt_pkg::COUNT_W-1:0] CNT_LIMIT =
      (MAX_PIXELS < 2097151) ? hvt_pkg::COUNT_W'(MAX_PIXELS) : {hvt_pkg::COUNT_W{1'b1}};

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_ACC_WR    = 4'd1;
   localparam logic [3:0] ST_TAP_START = 4'd2;
   localparam logic [3:0] ST_TAP_RD    = 4'd3;
   localparam logic [3:0] ST_TAP_MUL   = 4'd4;
   localparam logic [3:0] ST_TAP_ADD   = 4'd5;
   localparam logic [3:0] ST_SC_LO     = 4'd6;
   localparam logic [3:0] ST_SC_HI     = 4'd7;
   localparam logic [3:0] ST_SC_WR     = 4'd8;
   localparam logic [3:0] ST_P1_RD     = 4'd9;
   localparam logic [3:0] ST_P1_CMP    = 4'd10;
   localparam logic [3:0] ST_P2_RD     = 4'd11;
   localparam logic [3:0] ST_P2_CMP    = 4'd12;
   localparam logic [3:0] ST_V_RD      = 4'd13;
   localparam logic [3:0] ST_V_CMP     = 4'd14;
   localparam logic [3:0] ST_FIN_OUT   = 4'd15;

   // memories: histogram counts and smoothed bins
   logic [hvt_pkg::COUNT_W-1:0]  cnt_mem_ff [hvt_pkg::NBINS];
   logic [hvt_pkg::SMOOTH_W-1:0] sm_mem_ff  [hvt_pkg::NBINS];
   logic [hvt_pkg::NBINS-1:0]    cnt_valid_ff, cnt_valid_in;
   logic [hvt_pkg::COUNT_W-1:0]  cnt_q_ff;
   logic                         cnt_vq_ff;
   logic [hvt_pkg::SMOOTH_W-1:0] sm_q_ff;

   logic [5:0] cnt_raddr, sm_raddr;
   logic       cnt_we, sm_we;
   logic [5:0] cnt_waddr;
   logic [hvt_pkg::COUNT_W-1:0]  cnt_wdata;
   logic [hvt_pkg::SMOOTH_W-1:0] sm_wdata;

   logic [3:0] state_ff, state_in;
   logic [5:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [5:0] bin_ff, bin_in;
   logic [5:0] p1_ff, p1_in, p2_ff, p2_in, lo_ff, lo_in, hi_ff, hi_in, val_ff, val_in;
   logic       p2v_ff, p2v_in;
   logic [5:0] valley_ff, valley_in;
   logic [hvt_pkg::SMOOTH_W-1:0] best_ff, best_in;
   logic [hvt_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [hvt_pkg::PROD_W-1:0]   prod_ff, prod_lo_ff;
   logic [hvt_pkg::MUL_A_W-1:0]  mul_a;
   logic [hvt_pkg::MUL_B_W-1:0]  mul_b;
   logic                         rsp_valid_ff, rsp_valid_in;
   hvt_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   logic          out_free, req_xfer;
   logic [CW-1:0] pix_m, thr;
   logic [5:0]    pix_bin, j_start, j_end, dist_ij, dist_k;
   logic [hvt_pkg::COUNT_W-1:0] cnt_cur;
   logic [57:0]   scaled;
   logic          sm_gt, sm_lt;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign pix_m   = CW'(req_payload.pixel_value) & PIX_MASK;
   assign thr     = CW'(valley_ff) << SH;
   assign pix_bin = 6'(pix_m >> SH);

   assign j_start = (i_ff < 6'd7)  ? 6'd0  : (i_ff - 6'd7);
   assign j_end   = (i_ff > 6'd56) ? 6'd63 : (i_ff + 6'd7);
   assign dist_ij = (i_ff > j_ff) ? (i_ff - j_ff) : (j_ff - i_ff);
   assign dist_k  = (k_ff > p1_ff) ? (k_ff - p1_ff) : (p1_ff - k_ff);
   assign cnt_cur = cnt_vq_ff ? cnt_q_ff : '0;
   assign scaled  = (58'(prod_ff) << 20) + 58'(prod_lo_ff);
   assign sm_gt   = sm_q_ff > best_ff;
   assign sm_lt   = sm_q_ff < best_ff;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_TAP_MUL: begin
            mul_a = cnt_cur;
            mul_b = hvt_pkg::kweight(dist_ij);
         end
         ST_SC_LO: begin
            mul_a = hvt_pkg::MUL_A_W'(acc_ff[19:0]);
            mul_b = hvt_pkg::MUL_B_W'(hvt_pkg::recip(i_ff));
         end
         ST_SC_HI: begin
            mul_a = hvt_pkg::MUL_A_W'(acc_ff[hvt_pkg::ACC_W-1:20]);
            mul_b = hvt_pkg::MUL_B_W'(hvt_pkg::recip(i_ff));
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      bin_in       = bin_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      p2v_in       = p2v_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      val_in       = val_ff;
      best_in      = best_ff;
      acc_in       = acc_ff;
      valley_in    = valley_ff;
      cnt_valid_in = cnt_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      cnt_raddr    = j_ff;
      sm_raddr     = k_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = bin_ff;
      cnt_wdata    = cnt_cur + 1'b1;
      sm_we        = 1'b0;
      sm_wdata     = scaled[55:16];

      unique case (state_ff)
         ST_IDLE: begin
            cnt_raddr = pix_bin;
            if (req_xfer) begin
               // accumulate, classify and no-op answer now
               rsp_valid_in              = 1'b1;
               rsp_data_in.binary_out    = 1'b0;
               rsp_data_in.threshold_bin = valley_ff;
               bin_in                    = pix_bin;
               unique case (req_payload.func)
                  hvt_pkg::FUNC_ACCUM: begin
                     state_in = ST_ACC_WR;
                  end
                  hvt_pkg::FUNC_FINISH: begin
                     rsp_valid_in = 1'b0;
                     i_in         = '0;
                     state_in     = ST_TAP_START;
                  end
                  hvt_pkg::FUNC_CLASSIFY: begin
                     rsp_data_in.binary_out = pix_m > thr;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_ACC_WR: begin
            // saturating increment of the bin read last cycle
            if (cnt_cur < CNT_LIMIT) begin
               cnt_we               = 1'b1;
               cnt_valid_in[bin_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_TAP_START: begin
            j_in     = j_start;
            acc_in   = '0;
            state_in = ST_TAP_RD;
         end
         ST_TAP_RD: begin
            state_in = ST_TAP_MUL;
         end
         ST_TAP_MUL: begin
            state_in = ST_TAP_ADD;
         end
         ST_TAP_ADD: begin
            acc_in = acc_ff + hvt_pkg::ACC_W'(prod_ff);
            if (j_ff == j_end) begin
               state_in = ST_SC_LO;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_TAP_RD;
            end
         end
         ST_SC_LO: begin
            state_in = ST_SC_HI;
         end
         ST_SC_HI: begin
            state_in = ST_SC_WR;
         end
         ST_SC_WR: begin
            sm_we = 1'b1;
            if (i_ff == 6'd63) begin
               k_in     = '0;
               state_in = ST_P1_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_TAP_START;
            end
         end
         ST_P1_RD: begin
            state_in = ST_P1_CMP;
         end
         ST_P1_CMP: begin
            if (k_ff == 6'd0 || sm_gt) begin
               best_in = sm_q_ff;
               p1_in   = k_ff;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == 6'd63) begin
               p2v_in   = 1'b0;
               state_in = ST_P2_RD;
            end else begin
               state_in = ST_P1_RD;
            end
         end
         ST_P2_RD: begin
            state_in = ST_P2_CMP;
         end
         ST_P2_CMP: begin
            if (dist_k >= 6'(hvt_pkg::PEAK_GAP) && (!p2v_ff || sm_gt)) begin
               best_in = sm_q_ff;
               p2_in   = k_ff;
               p2v_in  = 1'b1;
            end
            if (k_ff == 6'd63) begin
               state_in = ST_V_RD;
               if (p2v_in) begin
                  lo_in = (p1_ff < p2_in) ? p1_ff : p2_in;
                  hi_in = (p1_ff < p2_in) ? p2_in : p1_ff;
               end else begin
                  lo_in = 6'(hvt_pkg::FALLBACK_BIN);
                  hi_in = 6'(hvt_pkg::FALLBACK_BIN);
               end
               k_in = lo_in;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_P2_RD;
            end
         end
         ST_V_RD: begin
            state_in = ST_V_CMP;
         end
         ST_V_CMP: begin
            if (k_ff == lo_ff || sm_lt) begin
               best_in = sm_q_ff;
               val_in  = k_ff;
            end
            if (k_ff == hi_ff) begin
               valley_in    = val_in;
               cnt_valid_in = '0;
               state_in     = ST_FIN_OUT;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_V_RD;
            end
         end
         ST_FIN_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.binary_out    = 1'b0;
               rsp_data_in.threshold_bin = valley_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valley_ff    <= 6'(hvt_pkg::FALLBACK_BIN);
         cnt_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valley_ff    <= valley_in;
         cnt_valid_ff <= cnt_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      bin_ff      <= bin_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      p2v_ff      <= p2v_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      val_ff      <= val_in;
      best_ff     <= best_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= hvt_pkg::PROD_W'(mul_a) * hvt_pkg::PROD_W'(mul_b);
      if (state_ff == ST_SC_HI) begin
         prod_lo_ff <= prod_ff;
      end
   end

   // memories, registered reads
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[cnt_waddr] <= cnt_wdata;
      end
      cnt_q_ff  <= cnt_mem_ff[cnt_raddr];
      cnt_vq_ff <= cnt_valid_ff[cnt_raddr];
   end

   always_ff @(posedge clock) begin
      if (sm_we) begin
         sm_mem_ff[i_ff] <= sm_wdata;
      end
      sm_q_ff <= sm_mem_ff[sm_raddr];
   end

   // checks
   `HVT_ASSERT_NEXT(a_acc_goes_write, clock, reset,
      req_xfer && req_payload.func == hvt_pkg::FUNC_ACCUM, state_ff == ST_ACC_WR,
      "accumulate transfer not followed by count write")
   `HVT_ASSERT_NEXT(a_clear_on_finish, clock, reset,
      state_ff == ST_V_CMP && k_ff == hi_ff, cnt_valid_ff == '0,
      "histogram not cleared at end of finish")
   `HVT_ASSERT_NEXT(a_valley_stable, clock, reset,
      state_ff != ST_V_CMP, $stable(valley_ff),
      "threshold changed outside the valley pass")
   `HVT_ASSERT_SAME(a_tap_in_range, clock, reset,
      state_ff == ST_TAP_ADD, j_ff >= j_start && j_ff <= j_end,
      "smoothing tap outside kernel window")

endmodule

### tb/sv/histogram_valley_threshold_test.sv
// Testbench for histogram_valley_threshold: drives pixel streams and finish items,
// predicts every result in-line and compares transfers. Depends on hvt_pkg.
module histogram_valley_threshold_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COUNT_CAP = 21'h1FFFFF < hvt_pkg::MAX_PIXELS_DEF ?
                                       21'h1FFFFF : hvt_pkg::MAX_PIXELS_DEF;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   hvt_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   hvt_pkg::rsp_type rsp_payload;

   histogram_valley_threshold DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [20:0]      hist_count [hvt_pkg::NBINS];
   logic [5:0]       valley_bin;
   hvt_pkg::rsp_type expected_rsp [$];
   int               error_count = 0;
   bit               idle_enabled = 1'b1;
   int               hold_off = 0;

   task automatic report(input string what);
      error_count++;
      $display("ERROR %0t: %s", $realtime, what);
   endtask

   function automatic logic [16:0] gauss_weight(input int d);
      int unsigned w [8] = '{65536, 52477, 26943, 8869, 1872, 253, 22, 1};
      if (d < 0) d = -d;
      return d <= 7 ? 17'(w[d]) : 17'd0;
   endfunction

   // smooth, locate both peaks, take the lowest bin between them, clear the histogram
   function automatic logic [5:0] find_valley();
      logic [39:0] smooth [hvt_pkg::NBINS];
      logic [63:0] acc, wsum, rcp;
      int first_pk, second_pk, lo, hi, v;
      first_pk = 0;
      second_pk = -1;
      for (int i = 0; i < hvt_pkg::NBINS; i++) begin
         acc = 0;
         wsum = 0;
         for (int j = 0; j < hvt_pkg::NBINS; j++) begin
            acc += 64'(hist_count[j]) * gauss_weight(i - j);
            wsum += gauss_weight(i - j);
         end
         rcp = ((64'd1 << 32) + wsum / 2) / wsum;
         smooth[i] = 40'((acc * rcp) >> 16);
      end
      for (int i = 1; i < hvt_pkg::NBINS; i++)
         if (smooth[i] > smooth[first_pk]) first_pk = i;
      for (int i = 0; i < hvt_pkg::NBINS; i++) begin
         int d;
         d = i > first_pk ? i - first_pk : first_pk - i;
         if (d >= hvt_pkg::PEAK_GAP && (second_pk < 0 || smooth[i] > smooth[second_pk]))
            second_pk = i;
      end
      if (second_pk < 0) begin
         lo = hvt_pkg::FALLBACK_BIN;
         hi = hvt_pkg::FALLBACK_BIN;
      end else begin
         lo = first_pk < second_pk ? first_pk : second_pk;
         hi = first_pk < second_pk ? second_pk : first_pk;
      end
      v = lo;
      for (int i = lo + 1; i <= hi; i++)
         if (smooth[i] < smooth[v]) v = i;
      for (int i = 0; i < hvt_pkg::NBINS; i++) hist_count[i] = '0;
      return 6'(v);
   endfunction

   function automatic hvt_pkg::rsp_type predict_pixel(input hvt_pkg::req_type item);
      hvt_pkg::rsp_type r;
      r = '0;
      case (item.func)
         hvt_pkg::FUNC_ACCUM: begin
            if (hist_count[item.pixel_value[15:10]] < COUNT_CAP)
               hist_count[item.pixel_value[15:10]]++;
         end
         hvt_pkg::FUNC_FINISH: valley_bin = find_valley();
         hvt_pkg::FUNC_CLASSIFY: r.binary_out = item.pixel_value > {valley_bin, 10'd0};
         default: ;
      endcase
      r.threshold_bin = valley_bin;
      return r;
   endfunction

   // offer one item, with an optional idle burst first; hold until the transfer
   task automatic send_pixel(input logic [1:0] func, input logic [15:0] pix);
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{func: func, pixel_value: pix};
      do @(posedge clock); while (!req_ready);
      expected_rsp.push_back(predict_pixel('{func: func, pixel_value: pix}));
   endtask

   // result side: random stall bursts, a long hold-off on request
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0)
               report("result transfer with nothing expected");
            else begin
               hvt_pkg::rsp_type want;
               want = expected_rsp.pop_front();
               if (rsp_payload.binary_out !== want.binary_out)
                  report($sformatf("binary_out %0b, want %0b", rsp_payload.binary_out,
                                   want.binary_out));
               if (rsp_payload.threshold_bin !== want.threshold_bin)
                  report($sformatf("threshold_bin %0d, want %0d",
                                   rsp_payload.threshold_bin, want.threshold_bin));
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else
            rsp_ready <= ~reset;
      end
   end

   // a mostly bimodal image of n pixels around two centres with stray classifies, then finish and four classifies
   task automatic send_image(input int n);
      int c1, c2;
      c1 = $urandom_range(0, 63);
      c2 = $urandom_range(0, 63);
      for (int k = 0; k < n; k++) begin
         int b;
         b = (k % 2 ? c1 : c2) + $urandom_range(0, 6) - 3;
         if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 63);
         b = b < 0 ? 0 : (b > 63 ? 63 : b);
         send_pixel(hvt_pkg::FUNC_ACCUM, {6'(b), 10'($urandom)});
         if ($urandom_range(0, 12) == 0) send_pixel(hvt_pkg::FUNC_CLASSIFY, 16'($urandom));
      end
      if ($urandom_range(0, 15) == 0) send_pixel(hvt_pkg::FUNC_UNDEF, 16'($urandom));
      send_pixel(hvt_pkg::FUNC_FINISH, 16'($urandom));
      for (int k = 0; k < 4; k++) send_pixel(hvt_pkg::FUNC_CLASSIFY, 16'($urandom));
   endtask

   task automatic test_directed();
      send_pixel(hvt_pkg::FUNC_CLASSIFY, 16'h8000);
      send_pixel(hvt_pkg::FUNC_CLASSIFY, 16'h8001);
      send_pixel(hvt_pkg::FUNC_FINISH, 16'hFFFF);    // empty histogram
      send_pixel(hvt_pkg::FUNC_ACCUM, 16'h0000);
      send_pixel(hvt_pkg::FUNC_ACCUM, 16'hFFFF);
      send_pixel(hvt_pkg::FUNC_ACCUM, 16'h5555);
      send_pixel(hvt_pkg::FUNC_ACCUM, 16'hAAAA);
      send_pixel(hvt_pkg::FUNC_UNDEF, 16'hFFFF);     // undefined func
      send_pixel(hvt_pkg::FUNC_FINISH, 16'h0000);
      send_pixel(hvt_pkg::FUNC_CLASSIFY, 16'h0000);
      send_pixel(hvt_pkg::FUNC_CLASSIFY, 16'hFFFF);
      send_pixel(hvt_pkg::FUNC_CLASSIFY, {valley_bin, 10'd0});
      send_pixel(hvt_pkg::FUNC_CLASSIFY, {valley_bin, 10'd1});
      for (int k = 0; k < 6; k++) send_pixel(hvt_pkg::FUNC_ACCUM, 16'h7C00); // one bin only
      send_pixel(hvt_pkg::FUNC_FINISH, 16'h0);
      send_pixel(hvt_pkg::FUNC_CLASSIFY, 16'h7FFF);
   endtask

   task automatic test_backpressure();
      hold_off = 300;
      for (int k = 0; k < 20; k++) send_pixel(hvt_pkg::FUNC_ACCUM, 16'($urandom));
      send_pixel(hvt_pkg::FUNC_FINISH, 16'h0);
   endtask

   task automatic test_random_images();
      for (int img = 0; img < 15; img++) send_image($urandom_range(30, 80));
   endtask

   task automatic test_streaming();
      idle_enabled = 1'b0;
      send_image(60);
   endtask

   initial begin
      for (int i = 0; i < hvt_pkg::NBINS; i++) hist_count[i] = '0;
      valley_bin = 6'(hvt_pkg::FALLBACK_BIN);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_images();
      test_streaming();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // about 20 finishes plus their pixels and stalls stay well inside this timeout
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule

### filelist.f
+incdir+design
design/hvt_pkg.sv
design/histogram_valley_threshold.sv
tb/sv/histogram_valley_threshold_test.sv
